@@ src/scp_pkg.sv @@
`timescale 1ns / 1ps

package scp_pkg;

    localparam int unsigned ANGLE_W = 10;
    localparam logic [ANGLE_W-1:0] MAX_ANGLE_RESET = 10'd90;

    localparam logic [1:0] CMD_CODE_BYTE  = 2'd0;
    localparam logic [1:0] CMD_CODE_ENTER = 2'd1;
    localparam logic [1:0] CMD_CODE_EXIT  = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_ENTER = 2'd1,
        KIND_EXIT  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        EV_NONE     = 4'd0,
        EV_MENU     = 4'd1,
        EV_PROMPT   = 4'd2,
        EV_APPLIED  = 4'd3,
        EV_SELERR   = 4'd4,
        EV_RANGEERR = 4'd5,
        EV_DIGIT    = 4'd6,
        EV_ERASED   = 4'd7,
        EV_EXITED   = 4'd8
    } event_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_SERVO = 3'b010,
        MODE_ANGLE = 3'b100
    } mode_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic       is_digit;
        logic       is_sel;
        logic       is_cr;
        logic       is_lf;
        logic       is_bs;
        logic [3:0] digit;
    } token_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ src/scp_front.sv @@
`timescale 1ns / 1ps

module scp_front
(
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             command,
    input  logic [7:0]             rx_byte,
    input  scp_pkg::queue_status_t q_status,
    output logic                   push,
    output scp_pkg::token_t        token
);

    logic [7:0] digit_full;

    assign in_ready   = !q_status.full;
    assign push       = in_valid && in_ready;
    assign digit_full = rx_byte - scp_pkg::CH_ZERO;

    always_comb
    begin
        case (command)
            scp_pkg::CMD_CODE_BYTE:  token.kind = scp_pkg::KIND_BYTE;
            scp_pkg::CMD_CODE_ENTER: token.kind = scp_pkg::KIND_ENTER;
            scp_pkg::CMD_CODE_EXIT:  token.kind = scp_pkg::KIND_EXIT;
            default:                 token.kind = scp_pkg::KIND_NONE;
        endcase
        token.ch       = rx_byte;
        token.is_digit = (rx_byte >= scp_pkg::CH_ZERO) && (rx_byte <= scp_pkg::CH_NINE);
        token.is_sel   = (rx_byte >= scp_pkg::CH_ZERO) && (rx_byte <= scp_pkg::CH_THREE);
        token.is_cr    = (rx_byte == scp_pkg::CH_CR);
        token.is_lf    = (rx_byte == scp_pkg::CH_LF);
        token.is_bs    = (rx_byte == scp_pkg::CH_BS) || (rx_byte == scp_pkg::CH_DEL);
        token.digit    = digit_full[3:0];
    end

endmodule

@@ src/scp_queue.sv @@
`timescale 1ns / 1ps

module scp_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  scp_pkg::token_t        push_token,
    input  logic                   pop,
    output scp_pkg::token_t        pop_token,
    output scp_pkg::queue_status_t status
);

    scp_pkg::token_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_token    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

@@ src/scp_back.sv @@
`timescale 1ns / 1ps

module scp_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [9:0]      max_angle,
    input  logic            q_valid,
    input  scp_pkg::token_t token,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [3:0]      event_res,
    output logic            echo_valid,
    output logic [7:0]      echo_byte,
    output logic            apply_valid,
    output logic [1:0]      servo_index,
    output logic [9:0]      angle_value
);

    logic [9:0]      max_angle_reg;
    scp_pkg::mode_t  mode_reg;
    scp_pkg::mode_t  mode_next;
    logic [1:0]      sel_reg;
    logic [1:0]      sel_next;
    logic [9:0]      sum_reg;
    logic [9:0]      sum_next;
    logic [1:0]      digits_reg;
    logic [1:0]      digits_next;
    logic            cr_reg;
    logic            cr_next;

    logic            out_valid_reg;
    logic            out_valid_next;
    scp_pkg::event_t ev_reg;
    scp_pkg::event_t ev_next;
    logic            echo_v_reg;
    logic            echo_v_next;
    logic [7:0]      echo_b_reg;
    logic [7:0]      echo_b_next;
    logic            apply_reg;
    logic            apply_next;
    logic [9:0]      shown_reg;
    logic [9:0]      shown_next;

    logic [13:0]     sum_x10;
    logic [17:0]     div_prod;
    logic [9:0]      sum_div10;
    logic            do_apply;
    logic [9:0]      apply_sum;

    assign cfg_ready   = 1'b1;
    assign pop         = q_valid && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;
    assign event_res   = ev_reg;
    assign echo_valid  = echo_v_reg;
    assign echo_byte   = echo_b_reg;
    assign apply_valid = apply_reg;
    assign servo_index = sel_reg;
    assign angle_value = shown_reg;

    // x*10 + d and x/10 as (x*205)>>11, exact for 10-bit x
    assign sum_x10   = {1'b0, sum_reg, 3'b000} + {3'b000, sum_reg, 1'b0} + {10'd0, token.digit};
    assign div_prod  = {8'd0, sum_reg} * 18'd205;
    assign sum_div10 = {3'd0, div_prod[17:11]};

    always_comb
    begin
        mode_next   = mode_reg;
        sel_next    = sel_reg;
        sum_next    = sum_reg;
        digits_next = digits_reg;
        cr_next     = cr_reg;
        ev_next     = scp_pkg::EV_NONE;
        echo_v_next = 1'b0;
        echo_b_next = 8'd0;
        apply_next  = 1'b0;
        do_apply    = 1'b0;
        apply_sum   = sum_reg;
        case (token.kind)
            scp_pkg::KIND_ENTER:
            begin
                sum_next    = 10'd0;
                digits_next = 2'd0;
                cr_next     = 1'b0;
                mode_next   = scp_pkg::MODE_SERVO;
                ev_next     = scp_pkg::EV_MENU;
            end
            scp_pkg::KIND_EXIT:
            begin
                mode_next = scp_pkg::MODE_IDLE;
                ev_next   = scp_pkg::EV_EXITED;
            end
            scp_pkg::KIND_BYTE:
            begin
                if (mode_reg != scp_pkg::MODE_IDLE)
                begin
                    if (cr_reg && token.is_lf)
                    begin
                        cr_next = 1'b0;
                    end
                    else
                    begin
                        cr_next = token.is_cr;
                        if (mode_reg == scp_pkg::MODE_SERVO)
                        begin
                            if (token.is_sel)
                            begin
                                echo_v_next = 1'b1;
                                echo_b_next = token.ch;
                                sel_next    = token.digit[1:0];
                                sum_next    = 10'd0;
                                digits_next = 2'd0;
                                mode_next   = scp_pkg::MODE_ANGLE;
                                ev_next     = scp_pkg::EV_PROMPT;
                            end
                            else if (token.is_cr)
                            begin
                                ev_next = scp_pkg::EV_MENU;
                            end
                            else
                            begin
                                echo_v_next = 1'b1;
                                echo_b_next = token.ch;
                                ev_next     = scp_pkg::EV_SELERR;
                            end
                        end
                        else
                        begin
                            if (token.is_digit)
                            begin
                                echo_v_next = 1'b1;
                                echo_b_next = token.ch;
                                apply_sum   = sum_x10[9:0];
                                sum_next    = sum_x10[9:0];
                                digits_next = digits_reg + 2'd1;
                                ev_next     = scp_pkg::EV_DIGIT;
                                do_apply    = (digits_reg == 2'd2);
                            end
                            else if (token.is_cr)
                            begin
                                if (digits_reg == 2'd0)
                                begin
                                    mode_next = scp_pkg::MODE_SERVO;
                                    ev_next   = scp_pkg::EV_MENU;
                                end
                                else
                                begin
                                    do_apply = 1'b1;
                                end
                            end
                            else if (token.is_bs && (digits_reg != 2'd0))
                            begin
                                digits_next = digits_reg - 2'd1;
                                sum_next    = sum_div10;
                                ev_next     = scp_pkg::EV_ERASED;
                            end
                            if (do_apply)
                            begin
                                if (apply_sum > max_angle_reg)
                                begin
                                    ev_next = scp_pkg::EV_RANGEERR;
                                end
                                else
                                begin
                                    ev_next    = scp_pkg::EV_APPLIED;
                                    apply_next = 1'b1;
                                    mode_next  = scp_pkg::MODE_SERVO;
                                end
                                sum_next    = 10'd0;
                                digits_next = 2'd0;
                            end
                        end
                    end
                end
            end
            default:
            begin
                ev_next = scp_pkg::EV_NONE;
            end
        endcase
        shown_next = do_apply ? apply_sum : sum_next;

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_angle_reg <= scp_pkg::MAX_ANGLE_RESET;
            mode_reg      <= scp_pkg::MODE_IDLE;
            sel_reg       <= 2'd0;
            sum_reg       <= 10'd0;
            digits_reg    <= 2'd0;
            cr_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_angle_reg <= max_angle;
            end
            if (pop)
            begin
                mode_reg   <= mode_next;
                sel_reg    <= sel_next;
                sum_reg    <= sum_next;
                digits_reg <= digits_next;
                cr_reg     <= cr_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ev_reg     <= ev_next;
            echo_v_reg <= echo_v_next;
            echo_b_reg <= echo_b_next;
            apply_reg  <= apply_next;
            shown_reg  <= shown_next;
        end
    end

endmodule

@@ src/serial_servo_command_parser.sv @@
`timescale 1ns / 1ps

// Terminal command parser for four servos. Each transfer on the input channel
// yields exactly one result transfer, in order. Throughput is one item per
// clock while the output is not stalled; an accepted item passes through the
// two-entry token queue and then through the output register. The queue
// lets input keep flowing for two items while the output is stalled. The
// max_angle register resets to 90 and is written through the cfg channel,
// which is always ready; write it only while no item is in flight.
module serial_servo_command_parser
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [7:0] rx_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [9:0] max_angle,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] event_res,
    output logic       echo_valid,
    output logic [7:0] echo_byte,
    output logic       apply_valid,
    output logic [1:0] servo_index,
    output logic [9:0] angle_value
);

    scp_pkg::queue_status_t q_status;
    scp_pkg::token_t        push_token;
    scp_pkg::token_t        pop_token;
    logic                   push;
    logic                   pop;

    scp_front u_front
    (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .rx_byte  (rx_byte),
        .q_status (q_status),
        .push     (push),
        .token    (push_token)
    );

    scp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .pop_token  (pop_token),
        .status     (q_status)
    );

    scp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .max_angle   (max_angle),
        .q_valid     (!q_status.empty),
        .token       (pop_token),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_res   (event_res),
        .echo_valid  (echo_valid),
        .echo_byte   (echo_byte),
        .apply_valid (apply_valid),
        .servo_index (servo_index),
        .angle_value (angle_value)
    );

    a_apply_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (apply_valid == (event_res == scp_pkg::EV_APPLIED)))
        else $error("apply flag disagrees with event");

    a_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !echo_valid) |-> (echo_byte == 8'd0))
        else $error("echo byte set without echo");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue both full and empty");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.full && !pop) |=> q_status.full)
        else $error("full queue lost an entry without a pop");

endmodule

@@ tb/serial_servo_command_parser_test.sv @@
`timescale 1ns / 1ps

module serial_servo_command_parser_test;

    localparam logic [1:0] CMD_CODE_NOP = 2'd3;
    localparam int         STALL_CYCLES = 60;
    localparam int         SETTLE_CYCLES = 4;

    typedef struct packed {
        scp_pkg::event_t ev;
        logic            echo_on;
        logic [7:0]      echo_ch;
        logic            apply_on;
        logic [1:0]      servo;
        logic [9:0]      angle;
    } servo_reply_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] command = scp_pkg::CMD_CODE_BYTE;
    logic [7:0] rx_byte = 8'h00;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [9:0] angle_limit = scp_pkg::MAX_ANGLE_RESET;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [3:0] event_res;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       apply_valid;
    logic [1:0] servo_index;
    logic [9:0] angle_value;

    logic       rx_hold = 1'b0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         items_sent = 0;
    int         mismatch_count = 0;

    servo_reply_t reply_q[$];

    scp_pkg::mode_t parse_mode = scp_pkg::MODE_IDLE;
    logic [1:0]     chosen_servo = 2'd0;
    logic [9:0]     line_sum = 10'd0;
    logic [1:0]     line_digits = 2'd0;
    logic           last_cr = 1'b0;
    logic [9:0]     accepted_limit = scp_pkg::MAX_ANGLE_RESET;

    serial_servo_command_parser dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .rx_byte(rx_byte),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .max_angle(angle_limit),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .event_res(event_res),
        .echo_valid(echo_valid),
        .echo_byte(echo_byte),
        .apply_valid(apply_valid),
        .servo_index(servo_index),
        .angle_value(angle_value)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic servo_reply_t parse_step(input logic [1:0] cmd,
                                                input logic [7:0] ch);
        servo_reply_t r;
        logic         fire;
        r = '{scp_pkg::EV_NONE, 1'b0, 8'h00, 1'b0, 2'd0, 10'd0};
        fire = 1'b0;
        if (cmd == scp_pkg::CMD_CODE_ENTER)
        begin
            line_sum = 10'd0;
            line_digits = 2'd0;
            last_cr = 1'b0;
            parse_mode = scp_pkg::MODE_SERVO;
            r.ev = scp_pkg::EV_MENU;
        end
        else if (cmd == scp_pkg::CMD_CODE_EXIT)
        begin
            parse_mode = scp_pkg::MODE_IDLE;
            r.ev = scp_pkg::EV_EXITED;
        end
        else if (cmd == scp_pkg::CMD_CODE_BYTE && parse_mode != scp_pkg::MODE_IDLE)
        begin
            if (last_cr && ch == scp_pkg::CH_LF)
            begin
                last_cr = 1'b0;
            end
            else
            begin
                last_cr = (ch == scp_pkg::CH_CR);
                if (parse_mode == scp_pkg::MODE_SERVO)
                begin
                    if (ch >= scp_pkg::CH_ZERO && ch <= scp_pkg::CH_THREE)
                    begin
                        r.echo_on = 1'b1;
                        r.echo_ch = ch;
                        chosen_servo = 2'(ch - scp_pkg::CH_ZERO);
                        line_sum = 10'd0;
                        line_digits = 2'd0;
                        parse_mode = scp_pkg::MODE_ANGLE;
                        r.ev = scp_pkg::EV_PROMPT;
                    end
                    else if (ch == scp_pkg::CH_CR)
                    begin
                        r.ev = scp_pkg::EV_MENU;
                    end
                    else
                    begin
                        r.echo_on = 1'b1;
                        r.echo_ch = ch;
                        r.ev = scp_pkg::EV_SELERR;
                    end
                end
                else
                begin
                    if (ch >= scp_pkg::CH_ZERO && ch <= scp_pkg::CH_NINE)
                    begin
                        r.echo_on = 1'b1;
                        r.echo_ch = ch;
                        line_sum = 10'(line_sum * 10 + (ch - scp_pkg::CH_ZERO));
                        line_digits = line_digits + 2'd1;
                        r.ev = scp_pkg::EV_DIGIT;
                        fire = (line_digits == 2'd3);
                    end
                    else if (ch == scp_pkg::CH_CR)
                    begin
                        if (line_digits == 2'd0)
                        begin
                            parse_mode = scp_pkg::MODE_SERVO;
                            r.ev = scp_pkg::EV_MENU;
                        end
                        else
                        begin
                            fire = 1'b1;
                        end
                    end
                    else if (ch == scp_pkg::CH_BS || ch == scp_pkg::CH_DEL)
                    begin
                        if (line_digits != 2'd0)
                        begin
                            line_digits = line_digits - 2'd1;
                            line_sum = line_sum / 10;
                            r.ev = scp_pkg::EV_ERASED;
                        end
                    end
                    if (fire)
                    begin
                        r.angle = line_sum;
                        if (line_sum > accepted_limit)
                        begin
                            r.ev = scp_pkg::EV_RANGEERR;
                        end
                        else
                        begin
                            r.ev = scp_pkg::EV_APPLIED;
                            r.apply_on = 1'b1;
                            parse_mode = scp_pkg::MODE_SERVO;
                        end
                        line_sum = 10'd0;
                        line_digits = 2'd0;
                    end
                end
            end
        end
        r.servo = chosen_servo;
        if (!fire)
            r.angle = line_sum;
        return r;
    endfunction

    task automatic log_mismatch(input string what, input servo_reply_t want,
                                input servo_reply_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t %s: expected ev=%0d echo=%0b/%02h apply=%0b servo=%0d angle=%0d",
                     $realtime, what, want.ev, want.echo_on, want.echo_ch, want.apply_on,
                     want.servo, want.angle);
            $display("    got ev=%0d echo=%0b/%02h apply=%0b servo=%0d angle=%0d",
                     got.ev, got.echo_on, got.echo_ch, got.apply_on, got.servo, got.angle);
        end
    endtask

    always @(posedge clk)
    begin
        servo_reply_t got;
        servo_reply_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                accepted_limit = angle_limit;
            if (in_valid && in_ready)
                reply_q.push_back(parse_step(command, rx_byte));
            if (out_valid && out_ready)
            begin
                got = '{scp_pkg::event_t'(event_res), echo_valid, echo_byte, apply_valid,
                        servo_index, angle_value};
                if (reply_q.size() == 0)
                begin
                    log_mismatch("unexpected result", '0, got);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (got !== want)
                        log_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    always @(posedge clk)
        out_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        rx_byte <= ch;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] ch);
        send_item(scp_pkg::CMD_CODE_BYTE, ch);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [9:0] value);
        drain();
        cfg_valid <= 1'b1;
        angle_limit <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_session();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
            return;
        end
        if (pick < 15)
        begin
            send_item(scp_pkg::CMD_CODE_EXIT, 8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(1))
            send_item(scp_pkg::CMD_CODE_ENTER, 8'($urandom_range(255)));
        pick = $urandom_range(99);
        if (pick < 80)
            send_byte(scp_pkg::CH_ZERO + 8'($urandom_range(3)));
        else if (pick < 88)
            send_byte(scp_pkg::CH_CR);
        else
            send_byte(8'($urandom_range(255)));
        n = $urandom_range(3);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_byte(pick < 4 ? scp_pkg::CH_BS : scp_pkg::CH_DEL);
            else if (pick < 12)
                send_byte(8'($urandom_range(255)));
            send_byte(scp_pkg::CH_ZERO + 8'($urandom_range(9)));
        end
        if (n < 3)
        begin
            send_byte(scp_pkg::CH_CR);
            if ($urandom_range(1))
                send_byte(scp_pkg::CH_LF);
        end
    endtask

    task automatic test_idle_and_commands();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_item(scp_pkg::CMD_CODE_EXIT, 8'h00);
        send_item(CMD_CODE_NOP, 8'hA5);
        send_item(scp_pkg::CMD_CODE_ENTER, 8'h5A);
        send_item(scp_pkg::CMD_CODE_ENTER, 8'hFF);
    endtask

    task automatic test_servo_selection();
        send_byte("x");
        send_byte(scp_pkg::CH_CR);
        send_byte(scp_pkg::CH_LF);
        send_byte(scp_pkg::CH_THREE);
        send_byte(scp_pkg::CH_CR);
    endtask

    task automatic test_angle_entry();
        send_byte("1");
        send_byte(scp_pkg::CH_BS);
        send_byte("z");
        send_byte("9");
        send_byte("1");
        send_byte(scp_pkg::CH_BS);
        send_byte(scp_pkg::CH_DEL);
        send_byte("9");
        send_byte("0");
        send_byte(scp_pkg::CH_CR);
        send_byte("2");
        send_byte("9");
        send_byte("9");
        send_byte("9");
        send_byte(scp_pkg::CH_ZERO);
        send_byte("4");
        send_byte("5");
    endtask

    task automatic test_range_limits();
        write_limit(10'd0);
        send_item(scp_pkg::CMD_CODE_ENTER, 8'h00);
        send_byte(scp_pkg::CH_ZERO);
        send_byte(scp_pkg::CH_ZERO);
        send_byte(scp_pkg::CH_ZERO);
        send_byte(scp_pkg::CH_ZERO);
        send_byte("1");
        send_byte(scp_pkg::CH_CR);
        write_limit(10'd999);
        send_item(scp_pkg::CMD_CODE_ENTER, 8'h00);
        send_byte("2");
        send_byte("9");
        send_byte("9");
        send_byte("9");
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        int goal;
        write_limit(10'($urandom_range(999)));
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        goal = items_sent + count;
        while (items_sent < goal)
            send_session();
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (STALL_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            repeat (8) send_session();
        join
    endtask

    initial
    begin
        #(12ns * 200000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_and_commands();
        test_servo_selection();
        test_angle_entry();
        test_range_limits();
        test_random_traffic(28, 46, 210);
        test_random_traffic(46, 28, 210);
        test_random_traffic(0, 0, 210);
        test_output_stall();
        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && reply_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
